FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Geometry, field widths, command codes, character codes, controller states
// and the command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  // Internal widths that follow from the geometry
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int X_W      = $clog2(COLUMNS);
  localparam int Y_W      = $clog2(ROWS + 1);
  localparam int INIT_ROW = (5 < ROWS) ? 5 : ROWS - 1;

  // Field widths of the stream items
  localparam int CMD_W        = 2;
  localparam int CHAR_W       = 8;
  localparam int COL_W        = 7;
  localparam int ROW_W        = 5;
  localparam int CELL_ADDR_W  = 11;
  localparam int ATTR_W       = 8;
  localparam int COLOR_W      = 4;
  localparam int CELL_W       = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
  localparam logic [COLOR_W-1:0]   FG_RESET     = 4'h7;
  localparam logic [COLOR_W-1:0]   BG_RESET     = 4'h0;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Grey-on-black blank cell
  localparam logic [CELL_W-1:0] BLANK_GREY = 16'h0720;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } tcw_cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_PUT,
    ST_BS_WR,
    ST_PUT_CHK,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_FILL,
    ST_CLEAR,
    ST_FINISH
  } tcw_state_e;

  typedef enum logic [2:0] {
    CUR_NONE,
    CUR_ADV,
    CUR_CR,
    CUR_LF,
    CUR_BACK,
    CUR_SET,
    CUR_HOME,
    CUR_SCROLL
  } tcw_cur_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CUR_CHAR,
    WR_CUR_BLANK,
    WR_SWEEP_GREY,
    WR_SWEEP_COPY,
    WR_SWEEP_BLANK
  } tcw_wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic        load_in;
    tcw_cur_op_e cur_op;
    tcw_wr_sel_e wr_sel;
    logic        rd_cell;
    logic        rd_copy;
    logic        sweep_clr;
    logic        sweep_inc;
    logic        out_load;
  } tcw_ctl_t;

  // Datapath to controller
  typedef struct packed {
    tcw_cmd_e cmd;
    logic     is_cr;
    logic     is_lf;
    logic     is_bs;
    logic     at_origin;
    logic     is_tab;
    logic     tab_aligned;
    logic     need_scroll;
    logic     sweep_last;
    logic     copy_last;
    logic     out_free;
  } tcw_sts_t;

endpackage

FILE: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console writer
// Walks each command through its steps: cell writes, cursor moves, the
// scroll copy and fill sweeps, the clear sweep and the result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_ctl_t ctl_o
);
  import tcw_pkg::*;

  tcw_state_e state_q, state_d;

  // State register; reset starts the clearing pass over the screen store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d         = state_q;
    ready_o         = 1'b0;
    ctl_o.load_in   = 1'b0;
    ctl_o.cur_op    = CUR_NONE;
    ctl_o.wr_sel    = WR_NONE;
    ctl_o.rd_cell   = 1'b0;
    ctl_o.rd_copy   = 1'b0;
    ctl_o.sweep_clr = 1'b0;
    ctl_o.sweep_inc = 1'b0;
    ctl_o.out_load  = 1'b0;

    case (state_q)
      ST_INIT: begin
        ctl_o.wr_sel    = WR_SWEEP_GREY;
        ctl_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (sts_i.cmd)
          CMD_PUT: begin
            if (sts_i.is_cr) begin
              ctl_o.cur_op = CUR_CR;
              state_d      = ST_PUT_CHK;
            end else if (sts_i.is_lf) begin
              ctl_o.cur_op = CUR_LF;
              state_d      = ST_PUT_CHK;
            end else if (sts_i.is_bs) begin
              // A backspace at the origin leaves everything as it is.
              if (sts_i.at_origin) begin
                state_d = ST_FINISH;
              end else begin
                ctl_o.cur_op = CUR_BACK;
                state_d      = ST_BS_WR;
              end
            end else begin
              state_d = ST_PUT;
            end
          end
          CMD_CLEAR: begin
            ctl_o.cur_op    = CUR_HOME;
            ctl_o.sweep_clr = 1'b1;
            state_d         = ST_CLEAR;
          end
          CMD_SET: begin
            ctl_o.cur_op = CUR_SET;
            state_d      = ST_FINISH;
          end
          default: begin
            ctl_o.rd_cell = 1'b1;
            state_d       = ST_FINISH;
          end
        endcase
      end

      // Write a character (a space for tab) at the cursor and advance.
      ST_PUT: begin
        ctl_o.wr_sel = WR_CUR_CHAR;
        ctl_o.cur_op = CUR_ADV;
        state_d      = ST_PUT_CHK;
      end

      ST_BS_WR: begin
        ctl_o.wr_sel = WR_CUR_BLANK;
        state_d      = ST_FINISH;
      end

      // Scroll if the cursor left the screen, else keep padding a tab.
      ST_PUT_CHK: begin
        if (sts_i.need_scroll) begin
          ctl_o.sweep_clr = 1'b1;
          state_d         = ST_SCR_RD;
        end else if (sts_i.is_tab && !sts_i.tab_aligned) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_SCR_RD: begin
        ctl_o.rd_copy = 1'b1;
        state_d       = ST_SCR_WR;
      end

      ST_SCR_WR: begin
        ctl_o.wr_sel    = WR_SWEEP_COPY;
        ctl_o.sweep_inc = 1'b1;
        state_d         = sts_i.copy_last ? ST_SCR_FILL : ST_SCR_RD;
      end

      // The cursor is at column 0 after any scroll, so a tab ends here.
      ST_SCR_FILL: begin
        ctl_o.wr_sel    = WR_SWEEP_BLANK;
        ctl_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          ctl_o.cur_op = CUR_SCROLL;
          state_d      = ST_FINISH;
        end
      end

      ST_CLEAR: begin
        ctl_o.wr_sel    = WR_SWEEP_GREY;
        ctl_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp: datapath of the text console writer
// Holds the request, the cursor, the colors, the sweep counter, the screen
// store and the result register, and reports status to the sequencer.
// ----------------------------------------------------------------------------
module tcw_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic [tcw_pkg::CMD_W-1:0]          in_cmd_i,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [tcw_pkg::COLOR_W-1:0]        cfg_data_i,
  // result
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    out_data_o,
  // sequencer
  input  tcw_pkg::tcw_ctl_t                  ctl_i,
  output tcw_pkg::tcw_sts_t                  sts_o
);
  import tcw_pkg::*;

  // Request registers
  tcw_cmd_e                 cmd_q;
  logic [CHAR_W-1:0]        char_q;
  logic [COL_W-1:0]         col_q;
  logic [ROW_W-1:0]         row_q;
  logic [CELL_ADDR_W-1:0]   addr_q;

  // Cursor, colors, sweep and flags
  logic [X_W-1:0]           x_q, x_d;
  logic [Y_W-1:0]           y_q, y_d;
  logic [COLOR_W-1:0]       fg_q, bg_q;
  logic [ADDR_W-1:0]        sweep_q;
  logic                     scrolled_q;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  // Screen store ports
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [CELL_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;

  logic [ADDR_W-1:0]        cur_off;
  logic [ATTR_W-1:0]        attr;
  logic                     is_tab;
  logic                     addr_ok;
  logic                     set_ok;
  logic [CELL_W-1:0]        rd_cell;

  assign cur_off = ADDR_W'(y_q) * ADDR_W'(COLUMNS) + ADDR_W'(x_q);
  assign attr    = {bg_q, fg_q};
  assign is_tab  = (char_q == CH_TAB);
  assign addr_ok = (int'(addr_q) < CELLS);
  assign set_ok  = (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q  <= tcw_cmd_e'(in_cmd_i);
      char_q <= in_data_i[7:0];
      col_q  <= in_data_i[14:8];
      row_q  <= in_data_i[19:15];
      addr_q <= in_data_i[30:20];
    end
  end

  // Color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_FG_COLOR) begin
        fg_q <= cfg_data_i;
      end else if (cfg_addr_i == CFG_BG_COLOR) begin
        bg_q <= cfg_data_i;
      end
    end
  end

  // Cursor moves
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    case (ctl_i.cur_op)
      CUR_ADV: begin
        if (x_q == X_W'(COLUMNS - 1)) begin
          x_d = '0;
          y_d = y_q + 1'b1;
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      CUR_CR: begin
        x_d = '0;
      end
      CUR_LF: begin
        x_d = '0;
        y_d = y_q + 1'b1;
      end
      CUR_BACK: begin
        if (x_q == '0) begin
          x_d = X_W'(COLUMNS - 1);
          y_d = y_q - 1'b1;
        end else begin
          x_d = x_q - 1'b1;
        end
      end
      CUR_SET: begin
        if (set_ok) begin
          x_d = X_W'(col_q);
          y_d = Y_W'(row_q);
        end
      end
      CUR_HOME: begin
        x_d = '0;
        y_d = '0;
      end
      CUR_SCROLL: begin
        y_d = Y_W'(ROWS - 1);
      end
      default: begin
        x_d = x_q;
        y_d = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= Y_W'(INIT_ROW);
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Scroll flag of the current request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scrolled_q <= 1'b0;
    end else if (ctl_i.load_in) begin
      scrolled_q <= 1'b0;
    end else if (ctl_i.cur_op == CUR_SCROLL) begin
      scrolled_q <= 1'b1;
    end
  end

  // Sweep counter for clearing, copying and filling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_inc) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // Screen store write port
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = sweep_q;
    ram_wdata = BLANK_GREY;
    case (ctl_i.wr_sel)
      WR_CUR_CHAR: begin
        ram_waddr = cur_off;
        ram_wdata = {attr, is_tab ? CH_SPACE : char_q};
      end
      WR_CUR_BLANK: begin
        ram_waddr = cur_off;
        ram_wdata = {attr, CH_SPACE};
      end
      WR_SWEEP_GREY: begin
        ram_wdata = BLANK_GREY;
      end
      WR_SWEEP_COPY: begin
        ram_wdata = ram_rdata;
      end
      WR_SWEEP_BLANK: begin
        ram_wdata = {attr, CH_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Screen store read port: a cell for the user, or the row below in a scroll
  assign ram_re    = (ctl_i.rd_cell && addr_ok) || ctl_i.rd_copy;
  assign ram_raddr = ctl_i.rd_copy ? (sweep_q + ADDR_W'(COLUMNS)) : ADDR_W'(addr_q);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  assign rd_cell = ((cmd_q == CMD_READ) && addr_ok) ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_data_q <= {scrolled_q, rd_cell[15:8], rd_cell[7:0],
                     CELL_ADDR_W'(cur_off), ROW_W'(y_q), COL_W'(x_q)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status toward the sequencer
  assign sts_o.cmd         = cmd_q;
  assign sts_o.is_cr       = (char_q == CH_CR);
  assign sts_o.is_lf       = (char_q == CH_LF);
  assign sts_o.is_bs       = (char_q == CH_BS);
  assign sts_o.at_origin   = (x_q == '0) && (y_q == '0);
  assign sts_o.is_tab      = is_tab;
  assign sts_o.tab_aligned = ((x_q % TAB_STOP) == 0);
  assign sts_o.need_scroll = (y_q >= Y_W'(ROWS));
  assign sts_o.sweep_last  = (sweep_q == ADDR_W'(CELLS - 1));
  assign sts_o.copy_last   = (sweep_q == ADDR_W'(CELLS - COLUMNS - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: 80x25 text-mode console engine
//
//   Channel  | Direction | Handshake                | Payload
//   ---------+-----------+--------------------------+---------------------------
//   s_axis   | in        | s_axis_tvalid/tready     | tuser cmd, tdata fields
//   m_axis   | out       | m_axis_tvalid/tready     | tdata cursor and cell
//   cfg      | in        | cfg_valid_i/cfg_ready_o  | cfg_addr_i, cfg_data_i
//
// One command is worked at a time. A scroll copies each row up and blanks the
// bottom row, and a clear blanks the whole screen, as the sweeps walk the
// screen store one cell at a time. After reset a clearing pass fills the store
// with blanks; s_axis_tready_o stays low until it ends. The next command is
// accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Commands. tuser: cmd[1:0].
  // tdata: char_code[7:0], col[14:8], row[19:15], cell_addr[30:20], zero[31].
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic [tcw_pkg::CMD_W-1:0]           s_axis_tuser_i,
  // Results. tdata: cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
  // cell_char[30:23], cell_attr[38:31], scrolled[39].
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // Register writes: 0 fg_color, 1 bg_color.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data_i
);
  import tcw_pkg::*;

  tcw_ctl_t ctl;
  tcw_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_cmd_i    (s_axis_tuser_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

`ifndef SYNTH
  // Only one command is in work: acceptance drops ready for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("command accepted while another is in work");

  // The reported cursor row lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[11:7]) < 32'(ROWS)))
    else $error("cursor row beyond the screen");

  // The reported offset agrees with the reported row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[22:12]) ==
      32'(m_axis_tdata_o[11:7]) * 32'(COLUMNS) + 32'(m_axis_tdata_o[6:0])))
    else $error("cursor offset does not match row and column");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the text console writer
// Console commands go in over the command stream in bursts of random length
// with random gaps, and the result stream stalls on a pattern of its own.
// A behavioral copy of the screen store, cursor and color registers predicts
// every result, which is then checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 320;
  localparam int MAX_REPORTS = 40;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG
  } rx_mode_e;

  typedef struct packed {
    tcw_cmd_e               cmd;
    logic [CHAR_W-1:0]      ch;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic [CELL_ADDR_W-1:0] addr;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]       cur_col;
    logic [ROW_W-1:0]       cur_row;
    logic [CELL_ADDR_W-1:0] cur_offset;
    logic [CHAR_W-1:0]      cell_char;
    logic [ATTR_W-1:0]      cell_attr;
    logic                   scrolled;
  } console_status_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]       s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_addr_i      = '0;
  logic [COLOR_W-1:0]     cfg_data_i      = '0;

  // Console model state.
  logic [CELL_W-1:0]  screen_mem [CELLS];
  int unsigned        cur_x;
  int unsigned        cur_y;
  logic [COLOR_W-1:0] fg_reg;
  logic [COLOR_W-1:0] bg_reg;

  console_req_t    pending_q [$];
  console_status_t status_q [$];
  console_req_t    cur_req      = '0;
  logic            req_taken    = 1'b0;
  int              burst_left   = 0;
  int              gap_left     = 0;
  rx_mode_e        rx_mode      = RX_OPEN;
  int              rx_left      = 0;
  int              rx_tick      = 0;
  int              idle_cycles  = 0;
  int              mismatch_cnt = 0;

  text_console_writer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // One character through the console; returns 1 when the screen scrolled.
  function automatic logic put_char(input logic [CHAR_W-1:0] ch);
    int i;
    case (ch)
      CH_CR: cur_x = 0;
      CH_LF: begin
        cur_y++;
        cur_x = 0;
      end
      CH_BS: begin
        // Backspace at the origin leaves everything as it is.
        if (cur_x == 0 && cur_y == 0)
          return 1'b0;
        if (cur_x == 0) begin
          cur_y--;
          cur_x = COLUMNS - 1;
        end else begin
          cur_x--;
        end
        screen_mem[cur_y * COLUMNS + cur_x] = {bg_reg, fg_reg, CH_SPACE};
      end
      default: begin
        screen_mem[cur_y * COLUMNS + cur_x] = {bg_reg, fg_reg, ch};
        cur_x++;
        if (cur_x >= COLUMNS) begin
          cur_x = 0;
          cur_y++;
        end
      end
    endcase
    if (cur_y < ROWS)
      return 1'b0;
    // Past the last row: move every row up and blank the bottom one.
    for (i = 0; i < CELLS - COLUMNS; i++)
      screen_mem[i] = screen_mem[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++)
      screen_mem[i] = {bg_reg, fg_reg, CH_SPACE};
    cur_y = ROWS - 1;
    return 1'b1;
  endfunction

  // Applies one command to the console model and returns its status.
  function automatic console_status_t advance_console(input console_req_t req);
    console_status_t st;
    int              i;
    st = '0;
    case (req.cmd)
      CMD_PUT: begin
        // A tab puts spaces until the column reaches the next tab stop.
        if (req.ch == CH_TAB) begin
          st.scrolled = put_char(CH_SPACE);
          while (cur_x % TAB_STOP != 0)
            st.scrolled |= put_char(CH_SPACE);
        end else begin
          st.scrolled = put_char(req.ch);
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++)
          screen_mem[i] = BLANK_GREY;
        cur_x = 0;
        cur_y = 0;
      end
      CMD_SET: begin
        if (req.col < COLUMNS && req.row < ROWS) begin
          cur_x = 32'(req.col);
          cur_y = 32'(req.row);
        end
      end
      default: begin
        if (req.addr < CELLS) begin
          st.cell_char = screen_mem[req.addr][CHAR_W-1:0];
          st.cell_attr = screen_mem[req.addr][CELL_W-1:CHAR_W];
        end
      end
    endcase
    st.cur_col    = COL_W'(cur_x);
    st.cur_row    = ROW_W'(cur_y);
    st.cur_offset = CELL_ADDR_W'(cur_y * COLUMNS + cur_x);
    return st;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72)
      return CHAR_W'($urandom_range(8'h20, 8'h7e));
    if (r < 84)
      return CHAR_W'($urandom_range(0, 255));
    case (r % 4)
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_BS;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic int pick_addr();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(0, CELLS - 1);
    return $urandom_range(0, 2047);
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatch_cnt < MAX_REPORTS)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic push_cmd(input tcw_cmd_e cmd, input int ch, input int col, input int row,
                          input int addr);
    console_req_t r;
    r.cmd  = cmd;
    r.ch   = CHAR_W'(ch);
    r.col  = COL_W'(col);
    r.row  = ROW_W'(row);
    r.addr = CELL_ADDR_W'(addr);
    pending_q.push_back(r);
  endtask

  // Put request with random values in the fields that put does not use.
  task automatic push_put(input int ch);
    push_cmd(CMD_PUT, ch, $urandom_range(0, 127), $urandom_range(0, 31), pick_addr());
  endtask

  // Register write; the model follows at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    if (idx == CFG_FG_COLOR)
      fg_reg = val;
    else if (idx == CFG_BG_COLOR)
      bg_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid_i || status_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Random command sequences; mostly text runs, with cursor moves, reads,
  // runs that start near the bottom right to force scrolls, a few clears,
  // and some requests with every field random.
  task automatic queue_random_phase(input int target);
    int n, k, kind, len;
    n = 0;
    while (n < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 48) begin
        len = $urandom_range(1, 16);
        for (k = 0; k < len; k++)
          push_put(pick_char());
        n += len;
      end else if (kind < 62) begin
        if ($urandom_range(0, 99) < 85)
          push_cmd(CMD_SET, $urandom_range(0, 255), $urandom_range(0, COLUMNS - 1),
                   $urandom_range(0, ROWS - 1), pick_addr());
        else
          push_cmd(CMD_SET, $urandom_range(0, 255), $urandom_range(0, 127),
                   $urandom_range(0, 31), pick_addr());
        n++;
      end else if (kind < 84) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          push_cmd(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 127),
                   $urandom_range(0, 31), pick_addr());
        n += len;
      end else if (kind < 88) begin
        len = $urandom_range(1, 20);
        push_cmd(CMD_SET, $urandom_range(0, 255), $urandom_range(COLUMNS - 20, COLUMNS - 1),
                 ROWS - 1, pick_addr());
        for (k = 0; k < len; k++)
          push_put(pick_char());
        n += len + 1;
      end else if (kind < 90) begin
        push_cmd(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 31), pick_addr());
        n++;
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++)
          push_cmd(tcw_cmd_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                   $urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 2047));
        n += len;
      end
    end
  endtask

  // Prediction happens at the edge that accepts the request.
  always @(posedge clk_i) begin : accept_cmds
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      status_q.push_back(advance_console(cur_req));
      req_taken = 1'b1;
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin : drive_cmds
    logic nxt_valid;
    nxt_valid = s_axis_tvalid_i;
    if (!s_axis_tvalid_i || req_taken) begin
      req_taken = 1'b0;
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        cur_req   = pending_q.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= {1'b0, cur_req.addr, cur_req.row, cur_req.col, cur_req.ch};
    s_axis_tuser_i  <= cur_req.cmd;
  end

  // Result ready: switches between randomly chosen stall patterns.
  always @(negedge clk_i) begin : drive_ready
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
      rx_tick = 0;
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready_i <= 1'b1;
      RX_COIN:     m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: m_axis_tready_i <= (rx_tick % 5 != 0);
      default:     m_axis_tready_i <= (rx_tick % 24 >= 16);
    endcase
  end

  // Result checker.
  always @(posedge clk_i) begin : check_results
    console_status_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (status_q.size() == 0) begin
        flag_mismatch("unexpected result, cursor_offset", 16'(m_axis_tdata_o[22:12]), '0);
      end else begin
        want = status_q.pop_front();
        if (m_axis_tdata_o[6:0] !== want.cur_col)
          flag_mismatch("cursor_col", 16'(m_axis_tdata_o[6:0]), 16'(want.cur_col));
        if (m_axis_tdata_o[11:7] !== want.cur_row)
          flag_mismatch("cursor_row", 16'(m_axis_tdata_o[11:7]), 16'(want.cur_row));
        if (m_axis_tdata_o[22:12] !== want.cur_offset)
          flag_mismatch("cursor_offset", 16'(m_axis_tdata_o[22:12]),
                        16'(want.cur_offset));
        if (m_axis_tdata_o[30:23] !== want.cell_char)
          flag_mismatch("cell_char", 16'(m_axis_tdata_o[30:23]), 16'(want.cell_char));
        if (m_axis_tdata_o[38:31] !== want.cell_attr)
          flag_mismatch("cell_attr", 16'(m_axis_tdata_o[38:31]), 16'(want.cell_attr));
        if (m_axis_tdata_o[39] !== want.scrolled)
          flag_mismatch("scrolled", 16'(m_axis_tdata_o[39]), 16'(want.scrolled));
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run_test
    int                 p, i;
    logic [COLOR_W-1:0] fg, bg;
    for (i = 0; i < CELLS; i++)
      screen_mem[i] = BLANK_GREY;
    cur_x  = 0;
    cur_y  = INIT_ROW;
    fg_reg = FG_RESET;
    bg_reg = BG_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset colors.
    push_cmd(CMD_READ, 0, 0, 0, 0);
    push_put(8'h41);
    push_put(8'hff);
    push_put(8'h00);
    push_cmd(CMD_READ, 0, 0, 0, INIT_ROW * COLUMNS);
    push_put(CH_TAB);
    push_put(CH_CR);
    push_put(CH_LF);
    push_put(CH_BS);
    // Printable character in the bottom right corner scrolls.
    push_cmd(CMD_SET, 0, COLUMNS - 1, ROWS - 1, 0);
    push_put(8'h5a);
    push_cmd(CMD_READ, 0, 0, 0, CELLS - 1);
    push_cmd(CMD_READ, 0, 0, 0, CELLS - COLUMNS - 1);
    push_cmd(CMD_READ, 8'hff, 127, 31, 2047);
    // Out of range cursor positions are ignored.
    push_cmd(CMD_SET, 8'hff, 127, 31, 2047);
    push_cmd(CMD_SET, 0, COLUMNS, 0, 0);
    push_cmd(CMD_SET, 0, 0, ROWS, 0);
    // Tab and line feed on the last row both scroll.
    push_cmd(CMD_SET, 0, COLUMNS - 2, ROWS - 1, 0);
    push_put(CH_TAB);
    push_cmd(CMD_SET, 0, 0, ROWS - 1, 0);
    push_put(CH_LF);
    // Backspace from column zero wraps to the row above.
    push_cmd(CMD_SET, 0, 0, 1, 0);
    push_put(CH_BS);
    push_cmd(CMD_READ, 0, 0, 0, COLUMNS - 1);
    push_cmd(CMD_CLEAR, 8'hff, 127, 31, 2047);
    push_put(CH_BS);
    push_cmd(CMD_READ, 8'hff, 127, 31, 0);

    // Random phases, each with its own colors; the sender waits for every
    // result before the registers change.
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          fg = 4'hf;
          bg = 4'hf;
        end
        1: begin
          fg = 4'h0;
          bg = 4'h0;
        end
        2: begin
          fg = 4'hf;
          bg = 4'h0;
        end
        3: begin
          fg = 4'h0;
          bg = 4'hf;
        end
        default: begin
          fg = COLOR_W'($urandom_range(0, 15));
          bg = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(CFG_FG_COLOR, fg);
      write_reg(CFG_BG_COLOR, bg);
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                COLOR_W'($urandom_range(0, 15)));
      queue_random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
dv/tb.sv
